// ===== rtl/afp_pkg.sv =====
// Package: shared widths, types and helpers for the three-point affine solver.
`default_nettype none
package afp_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COORD_FRAC  = COORD_WIDTH - 4;
  localparam int OUT_FRAC    = 16;
  localparam int OUT_WIDTH   = 32;
  // fraction alignment of the translation terms
  localparam int TSH = (COORD_FRAC <= OUT_FRAC) ? (OUT_FRAC - COORD_FRAC) : 0;
  localparam int DSH = (COORD_FRAC > OUT_FRAC) ? (COORD_FRAC - OUT_FRAC) : 0;

  localparam int DW   = COORD_WIDTH + 1;      // point differences
  localparam int PW   = 2 * DW;               // difference products
  localparam int DETW = PW + 1;               // determinant and adjugate terms
  localparam int TPW  = COORD_WIDTH + DETW;   // translation products
  localparam int TW   = TPW + 2;              // translation numerators
  localparam int NUMW = ((DETW + OUT_FRAC) > (TW + TSH)) ? (DETW + OUT_FRAC) : (TW + TSH);
  localparam int DENW = DETW + DSH;
  localparam int DVW  = ((NUMW > DENW) ? NUMW : DENW) + 2;  // divider operand magnitude
  localparam int QB   = OUT_WIDTH + 2;        // quotient bits, two above OUT_WIDTH for overflow detection
  localparam int REMW = DVW + QB;
  localparam int NCH  = 6;                    // coefficient channels
  localparam int FRONT_STAGES = 6;

  typedef logic signed [COORD_WIDTH-1:0] crd_t;
  typedef logic [DVW-1:0]                dv_t;
  typedef logic [OUT_WIDTH-1:0]          res_t;

  function automatic dv_t mag(input logic signed [DVW-1:0] v);
    mag = v[DVW-1] ? dv_t'(-v) : dv_t'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/affine_from_three_point_pairs.sv =====
// Top level: affine map from three point correspondences, fully pipelined.
//
// Usage notes
// - Command channel: an item (three source and three destination points,
//   signed Q3.12) transfers on a rising edge with start_i high and busy_o low.
//   busy_o is held low: the pipeline takes a new item on every cycle.
// - Result channel: done_o strobes for one cycle with coef_*_o and
//   shift_*_o (signed Q15.16, rounded half away from zero, saturated) and
//   singular_o. Collinear source points give singular_o high, all zeros.
// - Pipeline from the transfer edge to the strobed result:
//   6 front-end stages (differences, products, adjugate, translation
//   products, translation, operand prep), 34 divider stages, 1 output reg.
// - Throughput: one item per cycle, set by the six parallel dividers that
//   each retire one quotient bit per stage.
// - The receiver cannot stall; results are offered once and then gone.
// - Reset clears the valid bits only; items in flight are dropped.
`default_nettype none
module affine_from_three_point_pairs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  afp_pkg::crd_t src0_x_i, src0_y_i, src1_x_i, src1_y_i, src2_x_i, src2_y_i,
  input  afp_pkg::crd_t dst0_x_i, dst0_y_i, dst1_x_i, dst1_y_i, dst2_x_i, dst2_y_i,
  output logic          done_o,
  output afp_pkg::res_t coef_xx_o, coef_xy_o, coef_yx_o, coef_yy_o,
  output afp_pkg::res_t shift_x_o, shift_y_o,
  output logic          singular_o
);
  import afp_pkg::*;

  logic                 fe_vld, fe_sing;
  dv_t [NCH-1:0]        fe_num, fe_den;
  logic [NCH-1:0]       fe_neg;
  res_t [NCH-1:0]       dv_res;
  logic [QB-1:0]        vld_q, sing_q;   // flags alongside the divider stages
  logic                 done_q, singular_q;
  res_t [NCH-1:0]       res_q;

  assign busy_o = 1'b0;

  afp_solve u_solve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .p0x_i  (src0_x_i), .p0y_i (src0_y_i),
    .p1x_i  (src1_x_i), .p1y_i (src1_y_i),
    .p2x_i  (src2_x_i), .p2y_i (src2_y_i),
    .q0x_i  (dst0_x_i), .q0y_i (dst0_y_i),
    .q1x_i  (dst1_x_i), .q1y_i (dst1_y_i),
    .q2x_i  (dst2_x_i), .q2y_i (dst2_y_i),
    .vld_o  (fe_vld),
    .sing_o (fe_sing),
    .num_o  (fe_num),
    .den_o  (fe_den),
    .neg_o  (fe_neg)
  );

  // one divider per coefficient
  for (genvar c = 0; c < NCH; c++) begin : g_div
    afp_div u_div (
      .clk_i (clk_i),
      .num_i (fe_num[c]),
      .den_i (fe_den[c]),
      .neg_i (fe_neg[c]),
      .res_o (dv_res[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[QB-2:0], fe_vld};
      done_q <= vld_q[QB-1];
    end
  end

  // output register; a singular item forces every coefficient to zero
  always_ff @(posedge clk_i) begin
    sing_q     <= {sing_q[QB-2:0], fe_sing};
    singular_q <= sing_q[QB-1];
    for (int c = 0; c < NCH; c++) begin
      res_q[c] <= sing_q[QB-1] ? '0 : dv_res[c];
    end
  end

  assign done_o     = done_q;
  assign singular_o = singular_q;
  assign coef_xx_o  = res_q[0];
  assign coef_xy_o  = res_q[1];
  assign coef_yx_o  = res_q[2];
  assign coef_yy_o  = res_q[3];
  assign shift_x_o  = res_q[4];
  assign shift_y_o  = res_q[5];

endmodule
`default_nettype wire

// ===== rtl/afp_solve.sv =====
// Front end: differences, determinant, adjugate products, translation, divider operands.
`default_nettype none
module afp_solve (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  afp_pkg::crd_t                  p0x_i, p0y_i, p1x_i, p1y_i, p2x_i, p2y_i,
  input  afp_pkg::crd_t                  q0x_i, q0y_i, q1x_i, q1y_i, q2x_i, q2y_i,
  output logic                           vld_o,
  output logic                           sing_o,
  output afp_pkg::dv_t [afp_pkg::NCH-1:0] num_o,
  output afp_pkg::dv_t [afp_pkg::NCH-1:0] den_o,
  output logic [afp_pkg::NCH-1:0]        neg_o
);
  import afp_pkg::*;

  // stage 1: differences
  logic signed [DW-1:0] u1x_q, u1y_q, u2x_q, u2y_q, v1x_q, v1y_q, v2x_q, v2y_q;
  crd_t s1_p0x_q, s1_p0y_q, s1_q0x_q, s1_q0y_q;
  // stage 2: products
  logic signed [PW-1:0] pd0_q, pd1_q, pa0_q, pa1_q, pb0_q, pb1_q, pc0_q, pc1_q, pe0_q, pe1_q;
  crd_t s2_p0x_q, s2_p0y_q, s2_q0x_q, s2_q0y_q;
  // stage 3: determinant and adjugate numerators
  logic signed [DETW-1:0] s3_det_q, s3_nxx_q, s3_nxy_q, s3_nyx_q, s3_nyy_q;
  crd_t s3_p0x_q, s3_p0y_q, s3_q0x_q, s3_q0y_q;
  // stage 4: translation products
  logic signed [TPW-1:0] tqx_q, tnxx_q, tnxy_q, tqy_q, tnyx_q, tnyy_q;
  logic signed [DETW-1:0] s4_det_q, s4_nxx_q, s4_nxy_q, s4_nyx_q, s4_nyy_q;
  // stage 5: translation numerators
  logic signed [TW-1:0] s5_tx_q, s5_ty_q;
  logic signed [DETW-1:0] s5_det_q, s5_nxx_q, s5_nxy_q, s5_nyx_q, s5_nyy_q;
  // stage 6: unsigned divider operands
  dv_t [NCH-1:0] num_d, num_q, den_d, den_q;
  logic [NCH-1:0] neg_d, neg_q;
  logic sing_q;
  logic [FRONT_STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u1x_q <= DW'(p1x_i) - DW'(p0x_i);
    u1y_q <= DW'(p1y_i) - DW'(p0y_i);
    u2x_q <= DW'(p2x_i) - DW'(p0x_i);
    u2y_q <= DW'(p2y_i) - DW'(p0y_i);
    v1x_q <= DW'(q1x_i) - DW'(q0x_i);
    v1y_q <= DW'(q1y_i) - DW'(q0y_i);
    v2x_q <= DW'(q2x_i) - DW'(q0x_i);
    v2y_q <= DW'(q2y_i) - DW'(q0y_i);
    s1_p0x_q <= p0x_i;
    s1_p0y_q <= p0y_i;
    s1_q0x_q <= q0x_i;
    s1_q0y_q <= q0y_i;

    pd0_q <= u1x_q * u2y_q;
    pd1_q <= u2x_q * u1y_q;
    pa0_q <= v1x_q * u2y_q;
    pa1_q <= v2x_q * u1y_q;
    pb0_q <= v2x_q * u1x_q;
    pb1_q <= v1x_q * u2x_q;
    pc0_q <= v1y_q * u2y_q;
    pc1_q <= v2y_q * u1y_q;
    pe0_q <= v2y_q * u1x_q;
    pe1_q <= v1y_q * u2x_q;
    s2_p0x_q <= s1_p0x_q;
    s2_p0y_q <= s1_p0y_q;
    s2_q0x_q <= s1_q0x_q;
    s2_q0y_q <= s1_q0y_q;

    s3_det_q <= DETW'(pd0_q) - DETW'(pd1_q);
    s3_nxx_q <= DETW'(pa0_q) - DETW'(pa1_q);
    s3_nxy_q <= DETW'(pb0_q) - DETW'(pb1_q);
    s3_nyx_q <= DETW'(pc0_q) - DETW'(pc1_q);
    s3_nyy_q <= DETW'(pe0_q) - DETW'(pe1_q);
    s3_p0x_q <= s2_p0x_q;
    s3_p0y_q <= s2_p0y_q;
    s3_q0x_q <= s2_q0x_q;
    s3_q0y_q <= s2_q0y_q;

    tqx_q  <= s3_q0x_q * s3_det_q;
    tnxx_q <= s3_nxx_q * s3_p0x_q;
    tnxy_q <= s3_nxy_q * s3_p0y_q;
    tqy_q  <= s3_q0y_q * s3_det_q;
    tnyx_q <= s3_nyx_q * s3_p0x_q;
    tnyy_q <= s3_nyy_q * s3_p0y_q;
    s4_det_q <= s3_det_q;
    s4_nxx_q <= s3_nxx_q;
    s4_nxy_q <= s3_nxy_q;
    s4_nyx_q <= s3_nyx_q;
    s4_nyy_q <= s3_nyy_q;

    s5_tx_q <= TW'(tqx_q) - (TW'(tnxx_q) + TW'(tnxy_q));
    s5_ty_q <= TW'(tqy_q) - (TW'(tnyx_q) + TW'(tnyy_q));
    s5_det_q <= s4_det_q;
    s5_nxx_q <= s4_nxx_q;
    s5_nxy_q <= s4_nxy_q;
    s5_nyx_q <= s4_nyx_q;
    s5_nyy_q <= s4_nyy_q;

    num_q  <= num_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    sing_q <= (s5_det_q == '0);
  end

  // |n| * 2^k / |d| rounded: floor((2|n| * 2^k + |d|) / (2|d|))
  always_comb begin
    logic signed [DVW-1:0] nsg [NCH];
    logic signed [DVW-1:0] dsg;
    dv_t dm_c, dm_t;
    nsg[0] = DVW'(s5_nxx_q);
    nsg[1] = DVW'(s5_nxy_q);
    nsg[2] = DVW'(s5_nyx_q);
    nsg[3] = DVW'(s5_nyy_q);
    nsg[4] = DVW'(s5_tx_q);
    nsg[5] = DVW'(s5_ty_q);
    dsg  = DVW'(s5_det_q);
    dm_c = mag(dsg);
    dm_t = dm_c << DSH;
    for (int i = 0; i < NCH; i++) begin
      if (i < 4) begin
        num_d[i] = ((mag(nsg[i]) << OUT_FRAC) << 1) + dm_c;
        den_d[i] = dm_c << 1;
      end else begin
        num_d[i] = ((mag(nsg[i]) << TSH) << 1) + dm_t;
        den_d[i] = dm_t << 1;
      end
      neg_d[i] = nsg[i][DVW-1] ^ dsg[DVW-1];
    end
  end

  assign vld_o  = vld_q[FRONT_STAGES-1];
  assign sing_o = sing_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign neg_o  = neg_q;

endmodule
`default_nettype wire

// ===== rtl/afp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sign and saturation.
`default_nettype none
module afp_div (
  input  logic          clk_i,
  input  afp_pkg::dv_t  num_i,
  input  afp_pkg::dv_t  den_i,
  input  logic          neg_i,
  output afp_pkg::res_t res_o
);
  import afp_pkg::*;

  logic [REMW-1:0] rem_q [QB-1];
  dv_t             den_q [QB-1];
  logic [QB-1:0]   quo_q [QB];
  logic            neg_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stg
    logic [REMW-1:0] prem, dshf;
    dv_t             pden;
    logic [QB-1:0]   pquo;
    logic            pneg, ge;
    if (k == 0) begin : g_first
      assign prem = REMW'(num_i);
      assign pden = den_i;
      assign pquo = '0;
      assign pneg = neg_i;
    end else begin : g_next
      assign prem = rem_q[k-1];
      assign pden = den_q[k-1];
      assign pquo = quo_q[k-1];
      assign pneg = neg_q[k-1];
    end
    assign dshf = REMW'(pden) << (QB - 1 - k);
    assign ge   = (prem >= dshf);
    always_ff @(posedge clk_i) begin
      quo_q[k] <= pquo | (ge ? (QB'(1) << (QB - 1 - k)) : '0);
      neg_q[k] <= pneg;
    end
    if (k < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? (prem - dshf) : prem;
        den_q[k] <= pden;
      end
    end
  end

  logic [QB-1:0] qf;
  logic          nf;
  assign qf = quo_q[QB-1];
  assign nf = neg_q[QB-1];

  always_comb begin
    if (nf) begin
      if (qf[QB-1:OUT_WIDTH] != '0 || (qf[OUT_WIDTH-1] && qf[OUT_WIDTH-2:0] != '0)) begin
        res_o = {1'b1, {(OUT_WIDTH-1){1'b0}}};
      end else begin
        res_o = -qf[OUT_WIDTH-1:0];
      end
    end else begin
      if (qf[QB-1:OUT_WIDTH-1] != '0) begin
        res_o = {1'b0, {(OUT_WIDTH-1){1'b1}}};
      end else begin
        res_o = qf[OUT_WIDTH-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/afp_chk.sv =====
// Port checker for the affine solver, bound to the top level.
`default_nettype none
module afp_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input afp_pkg::res_t coef_xx_o, coef_xy_o, coef_yx_o, coef_yy_o,
  input afp_pkg::res_t shift_x_o, shift_y_o,
  input logic          singular_o
);
  import afp_pkg::*;

  localparam int LAT = FRONT_STAGES + QB + 1;

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised on a fully pipelined block");

  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("transfer without result after pipeline latency");

  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without matching transfer");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (coef_xx_o == '0 && coef_xy_o == '0 &&
      coef_yx_o == '0 && coef_yy_o == '0 && shift_x_o == '0 && shift_y_o == '0))
    else $error("singular result with non-zero coefficients");

endmodule

bind affine_from_three_point_pairs afp_chk u_afp_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .coef_xx_o  (coef_xx_o),
  .coef_xy_o  (coef_xy_o),
  .coef_yx_o  (coef_yx_o),
  .coef_yy_o  (coef_yy_o),
  .shift_x_o  (shift_x_o),
  .shift_y_o  (shift_y_o),
  .singular_o (singular_o)
);
`default_nettype wire
